/* rtl/core/fsd_pkg.sv */
// Shared types, constants and helpers for the Floyd-Steinberg RGB dither unit.
// Holds the fixed-point error format, saturation helper and register map.
// No dependencies; every other file in rtl/core but fsd_line_buf imports this package.
package fsd_pkg;

	// Error terms are signed 16-bit with FRAC_BITS fraction bits.
	localparam int FRAC_BITS   = 4;
	localparam int ERR_W       = 16;
	// Intermediate sums and weighted products fit in 19 signed bits.
	localparam int WIDE_W      = 19;
	localparam int PIX_W       = 8;
	localparam int LANES       = 3;
	localparam int MAX_WIDTH_DEF = 2048;

	// Configuration register widths and reset values.
	localparam int CFG_WIDTH_W  = 12;
	localparam int CFG_HEIGHT_W = 16;
	localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	// Full-scale value 255 in fixed point.
	localparam wide_t FULL_SCALE = wide_t'(255 << FRAC_BITS);
	localparam wide_t SAT_MAX    = wide_t'(32767);
	localparam wide_t SAT_MIN    = -wide_t'(32768);

	// Register index, decoded from the word address.
	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// Live configuration handed from the register block to the datapath.
	typedef struct packed {
		logic [CFG_WIDTH_W-1:0]  image_width;
		logic [CFG_HEIGHT_W-1:0] image_height;
	} cfg_t;

	// Position flags of one pixel within the frame, shared by all lanes.
	typedef struct packed {
		logic first_row;
		logic last_row;
		logic row_end;
	} pos_t;

	// Clamp a wide intermediate to the signed 16-bit range.
	function automatic err_t sat16(input wide_t v);
		err_t r;
		if (v > SAT_MAX) begin
			r = err_t'(SAT_MAX);
		end else if (v < SAT_MIN) begin
			r = err_t'(SAT_MIN);
		end else begin
			r = err_t'(v);
		end
		return r;
	endfunction

endpackage

/* rtl/core/fsd_if.sv */
// Stream interfaces of the dither unit: RGB pixels in, one bit per channel out.
// Each carries valid, ready and the payload; depends on fsd_pkg for widths.

// Input pixel stream.
interface fsd_pix_if
	import fsd_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;

	modport source(output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// Output stream of quantized channel bits.
interface fsd_bit_if;
	logic valid;
	logic ready;
	logic red_on;
	logic green_on;
	logic blue_on;

	modport source(output valid, output red_on, output green_on, output blue_on, input ready);
	modport sink(input valid, input red_on, input green_on, input blue_on, output ready);
endinterface

/* rtl/core/floyd_steinberg_dither_rgb_unit.sv */
// Top level of the Floyd-Steinberg RGB dither unit: counters, line buffer,
// three channel lanes and the merge into one output transaction.
// Depends on fsd_pkg, fsd_if, fsd_lane, fsd_line_buf and fsd_apb_regs.
//
//   Port      Kind          Direction  Transaction
//   pix_in    valid/ready   in         one RGB pixel, raster order
//   bit_out   valid/ready   out        one bit per channel for that pixel
//   APB       psel/penable  in/out     write or read of width or height
//
// One pixel per clock sustained while bit_out is ready; a pixel's result passes
// the lane stage, with the registered line-buffer read, and the output register.
// The right-carry feedback through each lane closes through the single register right_carry_q.
// arst_n clears counters, carries and valid flags; the line buffer is not
// cleared, since the first row of a frame ignores what it reads from it.
// A stall at bit_out holds the lane stage and then pix_in.ready drops.
module floyd_steinberg_dither_rgb_unit
	import fsd_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fsd_pix_if.sink               pix_in,
	fsd_bit_if.source             bit_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int CMP_W  = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
	localparam int WORD_W = LANES * ERR_W;

	cfg_t cfg;

	// Frame position counters.
	logic [COL_W-1:0]        col_q;
	logic [CFG_HEIGHT_W-1:0] row_q;
	logic [CMP_W-1:0]        w_eff;
	logic [CFG_HEIGHT_W-1:0] h_eff;
	pos_t                    pos_in;

	// Lane stage.
	logic                         s1_valid_q;
	logic [LANES-1:0][PIX_W-1:0]  px_s1;
	logic [COL_W-1:0]             x_s1;
	pos_t                         pos_s1;

	// Output register.
	logic             out_valid_q;
	logic [LANES-1:0] out_on_q;

	// Line buffer ports and forwarding.
	logic                         adv_we;
	logic                         we;
	logic [COL_W-1:0]             waddr;
	logic [WORD_W-1:0]            wdata;
	logic [WORD_W-1:0]            rdata;
	logic                         pend_valid_q;
	logic [COL_W-1:0]             pend_addr_q;
	logic [WORD_W-1:0]            pend_data_q;
	logic                         ovr_valid_q;
	logic [WORD_W-1:0]            ovr_data_q;
	logic [WORD_W-1:0]            above_word;

	logic                         accept;
	logic                         adv;
	logic [LANES-1:0]             lane_on;
	logic [LANES-1:0][ERR_W-1:0]  lane_left;
	logic [LANES-1:0][ERR_W-1:0]  lane_here;

	fsd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: the lane stage advances when the output register is free.
	assign adv          = s1_valid_q && (!out_valid_q || bit_out.ready);
	assign pix_in.ready = !s1_valid_q || adv;
	assign accept       = pix_in.valid && pix_in.ready;

	// Effective width and height, clamped to the supported range.
	always_comb begin
		if (cfg.image_width == '0) begin
			w_eff = CMP_W'(1);
		end else if (CMP_W'(cfg.image_width) > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = CMP_W'(cfg.image_width);
		end
		h_eff            = (cfg.image_height == '0) ? CFG_HEIGHT_W'(1) : cfg.image_height;
		pos_in.row_end   = CMP_W'(col_q) >= (w_eff - CMP_W'(1));
		pos_in.last_row  = row_q >= (h_eff - CFG_HEIGHT_W'(1));
		pos_in.first_row = row_q == '0;
	end

	// Column and row counters step on every input transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pos_in.row_end) begin
				col_q <= '0;
				row_q <= pos_in.last_row ? '0 : row_q + CFG_HEIGHT_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Lane stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix_in.ready) begin
			s1_valid_q <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1[0] <= pix_in.red_in;
			px_s1[1] <= pix_in.green_in;
			px_s1[2] <= pix_in.blue_in;
			x_s1     <= col_q;
			pos_s1   <= pos_in;
		end
	end

	// Line buffer writes: the below-left entry as the pixel leaves, and the
	// row-end entry in the following cycle, when the next pixel is in column zero.
	assign adv_we = adv && !pos_s1.last_row && (x_s1 != '0);
	assign we     = adv_we || pend_valid_q;
	assign waddr  = adv_we ? x_s1 - COL_W'(1) : pend_addr_q;
	assign wdata  = adv_we ? WORD_W'(lane_left) : pend_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else begin
			pend_valid_q <= adv && !pos_s1.last_row && pos_s1.row_end;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pend_addr_q <= x_s1;
			pend_data_q <= WORD_W'(lane_here);
		end
	end

	fsd_line_buf #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (WORD_W),
		.ADDR_W (COL_W)
	) u_line_buf (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (col_q),
		.rdata (rdata)
	);

	// Forward writes that land on the entry of the waiting pixel at or after
	// its read, since the buffer returns the older contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_valid_q <= 1'b0;
		end else if (accept) begin
			ovr_valid_q <= we && (waddr == col_q);
		end else if (s1_valid_q && we && (waddr == x_s1)) begin
			ovr_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if ((accept && we && (waddr == col_q)) ||
		    (!accept && s1_valid_q && we && (waddr == x_s1))) begin
			ovr_data_q <= wdata;
		end
	end

	// With a one-pixel row the row-end entry is still in flight while the
	// next row's pixel sits in the lane stage, so it is taken directly.
	assign above_word = (pend_valid_q && (pend_addr_q == x_s1)) ? pend_data_q :
	                    ovr_valid_q ? ovr_data_q : rdata;

	// One lane per color channel.
	for (genvar c = 0; c < LANES; c++) begin : g_lane
		fsd_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (adv),
			.px      (px_s1[c]),
			.above   (err_t'(above_word[c*ERR_W +: ERR_W])),
			.pos     (pos_s1),
			.on      (lane_on[c]),
			.wr_left (lane_left[c]),
			.wr_here (lane_here[c])
		);
	end

	// Merge the lane bits into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (bit_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_on_q <= lane_on;
		end
	end

	assign bit_out.valid    = out_valid_q;
	assign bit_out.red_on   = out_on_q[0];
	assign bit_out.green_on = out_on_q[1];
	assign bit_out.blue_on  = out_on_q[2];

	// The delayed row-end write never meets a below-left write.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_we && pend_valid_q))
		else $error("line buffer write port contention");

	// A pixel at the row end sends the column counter back to zero.
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_in.row_end) |=> (col_q == '0))
		else $error("column counter did not wrap at row end");

	// A full lane stage behind a stalled output blocks new input.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !bit_out.ready) |-> !pix_in.ready)
		else $error("input taken while the lane stage is blocked");

endmodule

/* rtl/core/fsd_lane.sv */
// One color channel of the dither datapath: quantizer and error diffusion.
// Keeps the right-neighbor carry and the two below-row partials of its channel.
// Depends on fsd_pkg for the error format and saturation helper.
module fsd_lane
	import fsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [PIX_W-1:0] px,
	input  err_t             above,
	input  pos_t             pos,
	output logic             on,
	output err_t             wr_left,
	output err_t             wr_here
);

	err_t  right_carry_q;
	err_t  near_q;
	err_t  far_q;

	wide_t px_w;
	wide_t sum_raw;
	err_t  sum;
	wide_t sum_w;
	err_t  err;
	wide_t e;
	wide_t p7;
	wide_t p5;
	wide_t p3;
	err_t  share7;
	err_t  share1;

	// Sum of pixel, right carry and the error diffused from the row above.
	always_comb begin
		px_w    = wide_t'({{(WIDE_W-PIX_W){1'b0}}, px}) <<< FRAC_BITS;
		sum_raw = px_w + wide_t'(right_carry_q) + (pos.first_row ? '0 : wide_t'(above));
		sum     = sat16(sum_raw);
		sum_w   = wide_t'(sum);
		on      = (sum_w <<< 1) > FULL_SCALE;
		err     = sat16(sum_w - (on ? FULL_SCALE : '0));
	end

	// Weighted shares as shift-adds, floored by the arithmetic shift.
	always_comb begin
		e       = wide_t'(err);
		p7      = (e <<< 3) - e;
		p5      = (e <<< 2) + e;
		p3      = (e <<< 1) + e;
		// Seven sixteenths of a 16-bit value always fits, so no clamp is needed.
		share7  = err_t'(p7 >>> 4);
		share1  = err >>> 4;
		wr_here = sat16(wide_t'(near_q) + (p5 >>> 4));
		wr_left = sat16(wide_t'(far_q) + (p3 >>> 4));
	end

	// Carry and partials move on when the pixel leaves the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_carry_q <= '0;
			near_q        <= '0;
			far_q         <= '0;
		end else if (step) begin
			right_carry_q <= pos.row_end ? '0 : share7;
			if (pos.last_row || pos.row_end) begin
				far_q  <= '0;
				near_q <= '0;
			end else begin
				far_q  <= wr_here;
				near_q <= share1;
			end
		end
	end

endmodule

/* rtl/core/fsd_line_buf.sv */
// Line buffer holding the pending error of the next row, all three channels.
// One write and one read port, registered read data; no dependencies.
module fsd_line_buf #(
	parameter int DEPTH  = 2048,
	parameter int DATA_W = 48,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; returns the contents before a write at the same edge.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/fsd_apb_regs.sv */
// APB register block of the dither unit: image width and image height.
// Word-addressed, writes take effect on the access phase; depends on fsd_pkg.
module fsd_apb_regs
	import fsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [CFG_WIDTH_W-1:0]  image_width_q;
	logic [CFG_HEIGHT_W-1:0] image_height_q;
	reg_idx_t                idx;
	logic                    wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RST;
			image_height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[CFG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[CFG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		unique case (idx)
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.image_width  = image_width_q;
	assign cfg.image_height = image_height_q;

endmodule
